FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/rtpfu_pkg.sv
// Package: widths, constants and shared types of the RTP fragment packetizer.
`timescale 1ns / 1ps
package rtpfu_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int FRAME_LEN_W = 24;
  localparam int TIME_W      = 32;
  localparam int SSRC_W      = 32;
  localparam int PT_W        = 7;
  localparam int MAXPAY_W    = 12;
  localparam int SEQ_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int HDR_BYTES   = 14;
  localparam int HDR_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] FRAG_FIRST  = 16'h1c89;
  localparam logic [15:0] FRAG_MIDDLE = 16'h1c09;
  localparam logic [15:0] FRAG_LAST   = 16'h1c49;
  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;

  localparam logic [CFG_IDX_W-1:0] REG_SSRC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXPAY = 2'd2;

  localparam logic [SSRC_W-1:0]   SSRC_RESET   = 32'd3334;
  localparam logic [PT_W-1:0]     PT_RESET     = 7'd96;
  localparam logic [MAXPAY_W-1:0] MAXPAY_RESET = 12'd1400;

  typedef struct packed {
    logic [SSRC_W-1:0]   ssrc;
    logic [PT_W-1:0]     pt;
    logic [MAXPAY_W-1:0] max_payload;
  } cfg_t;

  // One classified frame byte, as handed from front to back.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pend;
    logic              hdr;
    logic              marker;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] tstamp;
    logic [15:0]       frag;
  } entry_t;

endpackage

FILE: hw/rtl/rtpfu_front.sv
// Front end: accepts frame bytes, tracks frame/packet position, classifies.
`timescale 1ns / 1ps
module rtpfu_front (
  input  logic                                clk,
  input  logic                                rst,
  input  rtpfu_pkg::cfg_t                     cfg,
  input  logic                                accept,
  input  logic [rtpfu_pkg::BYTE_W-1:0]        payload_byte,
  input  logic [rtpfu_pkg::FRAME_LEN_W-1:0]   frame_length,
  input  logic [rtpfu_pkg::TIME_W-1:0]        frame_time,
  output rtpfu_pkg::entry_t                   entry
);

  localparam int LW = rtpfu_pkg::LENGTH_BITS;
  localparam int MW = rtpfu_pkg::MAXPAY_W;
  // packet-end math is wide enough for both the length and the max payload
  localparam int RW = ((LW > MW) ? LW : MW) + 1;

  logic [LW-1:0]                     frame_offset;
  logic [LW-1:0]                     held_length;
  logic [rtpfu_pkg::TIME_W-1:0]      held_time;
  logic [MW-1:0]                     packet_left;
  logic [rtpfu_pkg::SEQ_W-1:0]       sequence_count;

  logic                              off0;
  logic [LW-1:0]                     in_len;
  logic [LW-1:0]                     len;
  logic [rtpfu_pkg::TIME_W-1:0]      tm;
  logic                              hdr;
  logic [MW-1:0]                     mp;
  logic [RW-1:0]                     reach;
  logic                              last;
  logic [RW-1:0]                     rem;
  logic [MW-1:0]                     pl;
  logic [LW:0]                       off_inc;
  logic                              frame_done;

  always_comb begin
    off0    = (frame_offset == '0);
    in_len  = LW'(frame_length);
    if (in_len == '0) in_len = LW'(1);
    len     = off0 ? in_len : held_length;
    tm      = off0 ? frame_time : held_time;
    hdr     = off0 || (packet_left == '0);
    mp      = (cfg.max_payload == '0) ? MW'(1) : cfg.max_payload;
    reach   = RW'(frame_offset) + RW'(mp);
    last    = (reach >= RW'(len));
    rem     = RW'(len) - RW'(frame_offset);
    if (hdr) pl = last ? rem[MW-1:0] : mp;
    else     pl = packet_left;
    off_inc    = {1'b0, frame_offset} + (LW+1)'(1);
    frame_done = (off_inc >= {1'b0, len}) || (off_inc[LW-1:0] == '0);

    entry.data   = payload_byte;
    entry.pend   = (pl == MW'(1));
    entry.hdr    = hdr;
    entry.marker = last || off0;
    entry.seq    = sequence_count;
    entry.tstamp = tm;
    if (last)      entry.frag = rtpfu_pkg::FRAG_LAST;
    else if (off0) entry.frag = rtpfu_pkg::FRAG_FIRST;
    else           entry.frag = rtpfu_pkg::FRAG_MIDDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset   <= '0;
      held_length    <= '0;
      held_time      <= '0;
      packet_left    <= '0;
      sequence_count <= '0;
    end else if (accept) begin
      held_length <= len;
      held_time   <= tm;
      if (hdr) sequence_count <= sequence_count + 1'b1;
      if (frame_done) begin
        frame_offset <= '0;
        packet_left  <= '0;
      end else begin
        frame_offset <= off_inc[LW-1:0];
        packet_left  <= pl - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rtpfu_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module rtpfu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rtpfu_pkg::entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output rtpfu_pkg::entry_t  head,
  output logic               head_valid
);

  localparam int D  = rtpfu_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  rtpfu_pkg::entry_t slots [D];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full       = (count == CW'(D));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/rtpfu_back.sv
// Back end: serializes header bytes and payload byte into the output register.
`timescale 1ns / 1ps
module rtpfu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  rtpfu_pkg::cfg_t                cfg,
  input  rtpfu_pkg::entry_t              head,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rtpfu_pkg::BYTE_W-1:0]   out_byte,
  output logic                           packet_end,
  output logic                           run_end
);

  localparam int NB = rtpfu_pkg::HDR_BYTES;
  localparam int IW = rtpfu_pkg::HDR_IDX_W;

  logic [IW-1:0]          idx;
  logic [NB*8-1:0]        hdr_vec;
  logic                   free;
  logic                   load;
  logic                   pay;
  logic [IW-1:0]          sel;
  logic [7:0]             hdr_byte;

  always_comb begin
    hdr_vec = {rtpfu_pkg::RTP_VERSION_BYTE, head.marker, cfg.pt, head.seq,
               head.tstamp, cfg.ssrc, head.frag};
    free     = !out_valid || !out_stall;
    load     = head_valid && free;
    pay      = !head.hdr || (idx == IW'(NB));
    sel      = pay ? '0 : (IW'(NB - 1) - idx);
    hdr_byte = hdr_vec[sel*8 +: 8];
    pop      = load && pay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (free) out_valid <= head_valid;
      if (load) idx <= pay ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= pay ? head.data : hdr_byte;
      packet_end <= pay && head.pend;
      run_end    <= pay;
    end
  end

endmodule

FILE: hw/rtl/rtp_h264_fragment_packetizer_top.sv
// Top level of the RTP H.264 fragment packetizer.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_stall | payload_byte, frame_length, frame_time
//  output  | out_valid/out_stall | out_byte, packet_end, run_end
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One frame byte per cycle in while in_stall is low and one packet byte per
// cycle out while out_stall is low. A byte that opens a packet expands to 15
// output bytes (14 header bytes + payload), so the output side sets the rate.
// The two-entry queue between front and back absorbs output stalls; once it
// fills, in_stall rises until the back end pops. Synchronous reset clears
// frame position, sequence count, queue and output valid; config returns to
// its reset values. cfg_ready is always high.
`timescale 1ns / 1ps
module rtp_h264_fragment_packetizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rtpfu_pkg::BYTE_W-1:0]        payload_byte,
  input  logic [rtpfu_pkg::FRAME_LEN_W-1:0]   frame_length,
  input  logic [rtpfu_pkg::TIME_W-1:0]        frame_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rtpfu_pkg::BYTE_W-1:0]        out_byte,
  output logic                                packet_end,
  output logic                                run_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtpfu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpfu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rtpfu_pkg::cfg_t   cfg;
  rtpfu_pkg::entry_t front_entry;
  rtpfu_pkg::entry_t head;
  logic              q_full;
  logic              head_valid;
  logic              pop;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ssrc        <= rtpfu_pkg::SSRC_RESET;
      cfg.pt          <= rtpfu_pkg::PT_RESET;
      cfg.max_payload <= rtpfu_pkg::MAXPAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtpfu_pkg::REG_SSRC:   cfg.ssrc        <= cfg_data[rtpfu_pkg::SSRC_W-1:0];
        rtpfu_pkg::REG_PT:     cfg.pt          <= cfg_data[rtpfu_pkg::PT_W-1:0];
        rtpfu_pkg::REG_MAXPAY: cfg.max_payload <= cfg_data[rtpfu_pkg::MAXPAY_W-1:0];
        default: ;
      endcase
    end
  end

  rtpfu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .frame_time   (frame_time),
    .entry        (front_entry)
  );

  rtpfu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  rtpfu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .run_end    (run_end)
  );

endmodule

FILE: hw/rtl/rtpfu_checker.sv
// Port-level checker for the packetizer top, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtpfu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rtpfu_pkg::BYTE_W-1:0]  out_byte,
  input logic                          packet_end,
  input logic                          run_end
);

  // a stalled output item holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_byte))
  // packet end is always a payload byte, which ends its run
  `CHK_IMPL(a_pend_run, clk, rst, out_valid && packet_end, run_end)
  // nothing is presented right after reset
  `CHK_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind rtp_h264_fragment_packetizer_top rtpfu_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .packet_end (packet_end),
  .run_end    (run_end)
);

FILE: verif/tb_rtp_h264_fragment_packetizer_top.sv
// Testbench for the RTP H.264 fragment packetizer: directed table, random frames, self-checking.
`timescale 1ns / 1ps
module tb_rtp_h264_fragment_packetizer_top;

  // Register index that decodes to nothing; a write there must be dropped.
  localparam logic [rtpfu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DIR_ROWS = 32;
  localparam int RAND_ITEMS = 400;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table. Item rows with typed set carry a hand-written
  // header; such rows are all one-byte frames, so packet_end is always 1 there.
  typedef struct packed {
    row_kind_t                        kind;
    logic [rtpfu_pkg::CFG_IDX_W-1:0]  idx;
    logic [rtpfu_pkg::CFG_DATA_W-1:0] cdata;
    logic [7:0]                       data;
    logic [23:0]                      len;
    logic [31:0]                      ts;
    logic                             typed;
    logic [7:0]                       t_b1;
    logic [15:0]                      t_seq;
    logic [31:0]                      t_ssrc;
    logic [15:0]                      t_frag;
  } stim_row_t;

  // One byte of the outgoing packet stream.
  typedef struct packed {
    logic [7:0] data;
    logic       pend;
    logic       fin;
  } stream_byte_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [rtpfu_pkg::BYTE_W-1:0]       payload_byte = '0;
  logic [rtpfu_pkg::FRAME_LEN_W-1:0]  frame_length = '0;
  logic [rtpfu_pkg::TIME_W-1:0]       frame_time = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [rtpfu_pkg::BYTE_W-1:0]       out_byte;
  logic                               packet_end;
  logic                               run_end;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [rtpfu_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [rtpfu_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  rtp_h264_fragment_packetizer_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .payload_byte(payload_byte), .frame_length(frame_length), .frame_time(frame_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .packet_end(packet_end), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: registers and packetizer state.
  logic [rtpfu_pkg::SSRC_W-1:0]   ssrc_reg   = rtpfu_pkg::SSRC_RESET;
  logic [rtpfu_pkg::PT_W-1:0]     pt_reg     = rtpfu_pkg::PT_RESET;
  logic [rtpfu_pkg::MAXPAY_W-1:0] maxpay_reg = rtpfu_pkg::MAXPAY_RESET;
  logic [rtpfu_pkg::SEQ_W-1:0]    seq_num    = '0;
  logic [23:0]                    frame_pos  = '0;
  logic [23:0]                    frame_len  = '0;
  logic [31:0]                    frame_ts   = '0;
  logic [11:0]                    pkt_left   = '0;

  stream_byte_t due_stream[$];   // packet bytes still owed by the block, oldest first
  int unsigned  bad_count = 0;
  bit           calm = 1'b0;     // when set, neither side idles

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [111:0] rtp_header(input logic [7:0] b1, input logic [15:0] seq,
                                              input logic [31:0] ts, input logic [31:0] ssrc,
                                              input logic [15:0] frag);
    return {rtpfu_pkg::RTP_VERSION_BYTE, b1, seq, ts, ssrc, frag};
  endfunction

  // Advance the shadow state by one frame byte. opens says a header goes out
  // ahead of the byte; pend is the packet_end bit of the byte itself.
  task automatic packetize_byte(input logic [23:0] len_in, input logic [31:0] ts_in,
                                output logic opens, output logic [111:0] hdr,
                                output logic pend);
    logic [11:0] mp;
    logic [24:0] reach;
    logic        is_last, is_first;
    logic [15:0] frag;
    // length and timestamp latch on a frame's first byte; zero length means one
    if (frame_pos == 0) begin
      frame_len = (len_in == 0) ? 24'd1 : len_in;
      frame_ts  = ts_in;
      pkt_left  = '0;
    end
    opens = (pkt_left == 0);
    hdr = '0;
    if (opens) begin
      mp = (maxpay_reg == 0) ? 12'd1 : maxpay_reg;
      reach = frame_pos + mp;
      is_last  = (reach >= frame_len);
      is_first = (frame_pos == 0);
      frag = is_last ? rtpfu_pkg::FRAG_LAST :
             (is_first ? rtpfu_pkg::FRAG_FIRST : rtpfu_pkg::FRAG_MIDDLE);
      pkt_left = is_last ? 12'(frame_len - frame_pos) : mp;
      hdr = rtp_header({is_last | is_first, pt_reg}, seq_num, frame_ts, ssrc_reg, frag);
      seq_num = seq_num + 1'b1;
    end
    pkt_left  = pkt_left - 1'b1;
    frame_pos = frame_pos + 1'b1;
    pend = (pkt_left == 0);
    if (frame_pos >= frame_len || frame_pos == 0) begin
      frame_pos = '0;
      pkt_left  = '0;
    end
  endtask

  task automatic queue_packet_bytes(input logic opens, input logic [111:0] hdr,
                                    input logic [7:0] data, input logic pend);
    stream_byte_t sb;
    if (opens) begin
      for (int k = 13; k >= 0; k--) begin
        sb.data = hdr[k*8 +: 8];
        sb.pend = 1'b0;
        sb.fin  = 1'b0;
        due_stream.push_back(sb);
      end
    end
    sb.data = data;
    sb.pend = pend;
    sb.fin  = 1'b1;
    due_stream.push_back(sb);
  endtask

  // Present one frame byte and hold it until taken. With no gap, valid stays
  // up for the next item; otherwise it drops for the gap.
  task automatic send_byte(input logic [7:0] data, input logic [23:0] len,
                           input logic [31:0] ts, input int unsigned gap);
    in_valid     <= 1'b1;
    payload_byte <= data;
    frame_length <= len;
    frame_time   <= ts;
    do @(posedge clk); while (in_stall);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it before anything else moves.
  task automatic write_reg(input logic [rtpfu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtpfu_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rtpfu_pkg::REG_SSRC:   ssrc_reg   = val[rtpfu_pkg::SSRC_W-1:0];
      rtpfu_pkg::REG_PT:     pt_reg     = val[rtpfu_pkg::PT_W-1:0];
      rtpfu_pkg::REG_MAXPAY: maxpay_reg = val[rtpfu_pkg::MAXPAY_W-1:0];
      default: ;
    endcase
  endtask

  // Sender holds off until every owed byte is out. Each item yields at least
  // one byte, so an empty store means the block has nothing in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_stream.size() != 0) @(posedge clk);
  endtask

  // Output side back-pressure.
  initial begin : out_pacer
    int unsigned n;
    @(posedge clk);
    forever begin
      n = gap_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare each taken output item with the oldest owed byte.
  always @(posedge clk) begin : check_out
    stream_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_stream.size() == 0) begin
        bad_count++;
        if (bad_count < 40)
          $display("%0t: unexpected item: expected none, got byte %02h end %b run %b",
                   $time, out_byte, packet_end, run_end);
      end else begin
        want = due_stream.pop_front();
        if (out_byte !== want.data) begin
          bad_count++;
          if (bad_count < 40)
            $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
        end
        if (packet_end !== want.pend) begin
          bad_count++;
          if (bad_count < 40)
            $display("%0t: packet_end expected %b got %b", $time, want.pend, packet_end);
        end
        if (run_end !== want.fin) begin
          bad_count++;
          if (bad_count < 40)
            $display("%0t: run_end expected %b got %b", $time, want.fin, run_end);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t    dir [DIR_ROWS];
    stim_row_t    row;
    logic         opens, pend;
    logic [111:0] hdr;
    logic [23:0]  len;
    logic [31:0]  ts;
    logic [11:0]  mp;
    int unsigned  sent, phase_items;

    //          kind      idx         cdata          data   len          ts
    //          typed b1     seq     ssrc           frag
    // one-byte frames right after reset, zero length read as one
    dir[0]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h00, 24'd1,       32'h0000_0000,
                1'b1, 8'he0, 16'd0, 32'd3334,      rtpfu_pkg::FRAG_LAST};
    dir[1]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hff, 24'd0,       32'hffff_ffff,
                1'b1, 8'he0, 16'd1, 32'd3334,      rtpfu_pkg::FRAG_LAST};
    // all-ones SSRC and payload type
    dir[2]  = '{ROW_CFG,  rtpfu_pkg::REG_SSRC,   32'hffff_ffff, 8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[3]  = '{ROW_CFG,  rtpfu_pkg::REG_PT,     32'h7f,        8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[4]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h80, 24'd1,       32'h8000_0001,
                1'b1, 8'hff, 16'd2, 32'hffff_ffff, rtpfu_pkg::FRAG_LAST};
    // five-byte frame in two-byte packets: first, middle, last
    dir[5]  = '{ROW_CFG,  rtpfu_pkg::REG_MAXPAY, 32'd2,         8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[6]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'ha5, 24'd5,       32'h1234_5678,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[7]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h5a, 24'hff_ffff, 32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[8]  = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h3c, 24'd0,       32'hffff_ffff,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    // payload type change inside the frame, seen at the next header
    dir[9]  = '{ROW_CFG,  rtpfu_pkg::REG_PT,     32'h0,         8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[10] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hc3, 24'd9,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[11] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h0f, 24'd9,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    // write to an unmapped index, then zero max payload (acts as one)
    dir[12] = '{ROW_CFG,  REG_UNUSED, 32'hdead_beef, 8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[13] = '{ROW_CFG,  rtpfu_pkg::REG_MAXPAY, 32'd0,         8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[14] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h11, 24'd3,       32'h00ff_00ff,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[15] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h22, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[16] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h33, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    // zero SSRC, largest max payload: whole frame in one packet
    dir[17] = '{ROW_CFG,  rtpfu_pkg::REG_SSRC,   32'h0,         8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[18] = '{ROW_CFG,  rtpfu_pkg::REG_MAXPAY, 32'hfff,       8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[19] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h44, 24'd5,       32'hff00_ff00,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[20] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h55, 24'd1,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[21] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h66, 24'd1,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[22] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h77, 24'd1,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[23] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h88, 24'd1,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    // frame exactly one packet long, then one byte over
    dir[24] = '{ROW_CFG,  rtpfu_pkg::REG_MAXPAY, 32'd3,         8'h00, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[25] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'h99, 24'd3,       32'h0a0b_0c0d,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[26] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'haa, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[27] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hbb, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[28] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hcc, 24'd4,       32'h5555_aaaa,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[29] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hdd, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[30] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hee, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};
    dir[31] = '{ROW_ITEM, rtpfu_pkg::REG_SSRC,   32'h0,         8'hf0, 24'd0,       32'h0,
                1'b0, 8'h00, 16'd0, 32'h0,         16'h0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Register rows wait for the block to drain first.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.idx, row.cdata);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        packetize_byte(row.len, row.ts, opens, hdr, pend);
        if (row.typed)
          queue_packet_bytes(1'b1, rtp_header(row.t_b1, row.t_seq, row.ts, row.t_ssrc,
                                              row.t_frag), row.data, 1'b1);
        else
          queue_packet_bytes(opens, hdr, row.data, pend);
        send_byte(row.data, row.len, row.ts, gap_len());
      end
    end

    // Random phases: drain, maybe reprogram (often mid-frame), then a burst of
    // frame bytes. Frames are kept short so that most bytes see header
    // boundaries; bytes past a frame's first carry noise in length and time.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1))
        write_reg(rtpfu_pkg::REG_SSRC, ($urandom_range(0, 9) == 0) ? 32'h0 :
                                       ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : $urandom);
      if ($urandom_range(0, 1))
        write_reg(rtpfu_pkg::REG_PT,
                  ($urandom_range(0, 7) == 0) ? 32'd127 : $urandom_range(0, 127));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       mp = 12'd0;
          1:       mp = 12'hfff;
          2, 3:    mp = 12'($urandom_range(7, 300));
          default: mp = 12'($urandom_range(1, 6));
        endcase
        write_reg(rtpfu_pkg::REG_MAXPAY, {20'h0, mp});
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(REG_UNUSED, $urandom);
      cfg_valid <= 1'b0;

      phase_items = $urandom_range(4, 40);
      repeat (phase_items) begin
        if (frame_pos == 0) begin
          case ($urandom_range(0, 19))
            0:       len = 24'd0;
            1:       len = 24'($urandom_range(61, 200));
            2, 3, 4: len = 24'($urandom_range(13, 60));
            default: len = 24'($urandom_range(1, 12));
          endcase
        end else begin
          len = 24'($urandom);
        end
        ts = $urandom;
        row.data = 8'($urandom_range(0, 255));
        packetize_byte(len, ts, opens, hdr, pend);
        queue_packet_bytes(opens, hdr, row.data, pend);
        send_byte(row.data, len, ts, gap_len());
        sent++;
      end
    end

    // Drain, then give stray items a chance to show up.
    wait_idle();
    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (bad_count == 0 && due_stream.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
